[hdl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the following clock edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/u8d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// types, constants and lead byte decode for the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W  = 31;
  localparam int LEN_W = 3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // lead byte range starts
  localparam logic [7:0] CONT_BASE  = 8'h80;
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] LEAD5_BASE = 8'hF8;
  localparam logic [7:0] LEAD6_BASE = 8'hFC;
  localparam logic [7:0] BAD_BASE   = 8'hFE;

  // payload masks
  localparam logic [5:0] CONT_MASK  = 6'h3F;
  localparam logic [4:0] LEAD2_MASK = 5'h1F;
  localparam logic [4:0] LEAD3_MASK = 5'h0F;
  localparam logic [4:0] LEAD4_MASK = 5'h07;
  localparam logic [4:0] LEAD5_MASK = 5'h03;
  localparam logic [4:0] LEAD6_MASK = 5'h01;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic             multi;
    logic             invalid;
    logic [LEN_W-1:0] len;
    logic [4:0]       val;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r.multi   = 1'b1;
    r.invalid = 1'b0;
    r.len     = 3'd1;
    r.val     = 5'd0;
    if (b < CONT_BASE) begin
      r.multi = 1'b0;
    end else if (b < LEAD2_BASE) begin
      r.multi   = 1'b0;
      r.invalid = 1'b1;
    end else if (b < LEAD3_BASE) begin
      r.len = 3'd2;
      r.val = b[4:0] & LEAD2_MASK;
    end else if (b < LEAD4_BASE) begin
      r.len = 3'd3;
      r.val = b[4:0] & LEAD3_MASK;
    end else if (b < LEAD5_BASE) begin
      r.len = 3'd4;
      r.val = b[4:0] & LEAD4_MASK;
    end else if (b < LEAD6_BASE) begin
      r.len = 3'd5;
      r.val = b[4:0] & LEAD5_MASK;
    end else if (b < BAD_BASE) begin
      r.len = 3'd6;
      r.val = b[4:0] & LEAD6_MASK;
    end else begin
      r.multi   = 1'b0;
      r.invalid = 1'b1;
    end
    return r;
  endfunction

endpackage

[hdl/u8d_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_if
// byte request channel and code point request channel
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8d_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [2:0]  seq_length;
  logic [1:0]  status;

  modport source (output valid, output code_point, output seq_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input seq_length, input status,
                  output ready);
endinterface

[hdl/u8d_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_in_stage
// input register for incoming byte requests
// ----------------------------------------------------------------------------
module u8d_in_stage (
  input  logic           clk,
  input  logic           rst,
  u8d_byte_if.sink       text,
  output logic           item_valid,
  output u8d_pkg::item_t item,
  input  logic           item_take
);
  import u8d_pkg::*;

  logic  valid;
  item_t data;

  assign text.ready = !rst && (!valid || item_take);
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      valid <= 1'b1;
    end else if (item_take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      data.in_byte   <= text.in_byte;
      data.last_byte <= text.last_byte;
    end
  end

endmodule

[hdl/u8d_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_core
// sequence state, one-step decode and result register
// ----------------------------------------------------------------------------
module u8d_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  u8d_pkg::item_t item,
  output logic           item_take,
  u8d_cp_if.source       chars
);
  import u8d_pkg::*;

  logic [LEN_W-1:0] owed, owed_next;
  logic [CP_W-1:0]  partial, partial_next;
  logic [LEN_W-1:0] plen, plen_next;

  logic             out_valid;
  logic [CP_W-1:0]  out_cp;
  logic [LEN_W-1:0] out_len;
  status_t          out_st;

  logic             emit;
  logic [CP_W-1:0]  emit_cp;
  logic [LEN_W-1:0] emit_len;
  status_t          emit_st;

  lead_t            lead;
  logic [CP_W-1:0]  shifted;
  logic [LEN_W-1:0] owed_dec;

  assign item_take = item_valid && (!out_valid || chars.ready);

  always_comb begin
    lead         = lead_decode(item.in_byte);
    shifted      = {partial[CP_W-7:0], item.in_byte[5:0] & CONT_MASK};
    owed_dec     = owed - 3'd1;
    emit         = 1'b0;
    emit_cp      = '0;
    emit_len     = '0;
    emit_st      = ST_OK;
    owed_next    = owed;
    partial_next = partial;
    plen_next    = plen;
    if (owed != 3'd0) begin
      // any byte in continuation position only contributes its low six bits
      if (owed_dec == 3'd0) begin
        emit         = 1'b1;
        emit_cp      = shifted;
        emit_len     = plen;
        owed_next    = '0;
        partial_next = '0;
        plen_next    = '0;
      end else if (item.last_byte) begin
        emit         = 1'b1;
        emit_len     = plen;
        emit_st      = ST_TRUNC;
        owed_next    = '0;
        partial_next = '0;
        plen_next    = '0;
      end else begin
        partial_next = shifted;
        owed_next    = owed_dec;
      end
    end else if (!lead.multi) begin
      emit     = 1'b1;
      emit_cp  = {{(CP_W-8){1'b0}}, item.in_byte};
      emit_len = 3'd1;
      emit_st  = lead.invalid ? ST_INVALID : ST_OK;
    end else if (item.last_byte) begin
      emit     = 1'b1;
      emit_len = lead.len;
      emit_st  = ST_TRUNC;
    end else begin
      plen_next    = lead.len;
      owed_next    = lead.len - 3'd1;
      partial_next = {{(CP_W-5){1'b0}}, lead.val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owed    <= '0;
      partial <= '0;
      plen    <= '0;
    end else if (item_take) begin
      owed    <= owed_next;
      partial <= partial_next;
      plen    <= plen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take && emit) begin
      out_valid <= 1'b1;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_cp  <= emit_cp;
      out_len <= emit_len;
      out_st  <= emit_st;
    end
  end

  assign chars.valid      = out_valid;
  assign chars.code_point = out_cp;
  assign chars.seq_length = out_len;
  assign chars.status     = out_st;

endmodule

[hdl/utf8_stream_decoder.sv]
`timescale 1ns / 1ps
// path: an accepted byte request is held in the input register, and its result in the result register
// throughput: one byte per cycle unless the code point side stalls, set by the combinational decode step between
//   the input register and the result register
// reset: rst clears the pending sequence, both valid flags and input ready
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// decodes one to six byte utf-8 forms into code points with status
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic     clk,
  input  logic     rst,
  u8d_byte_if.sink text,
  u8d_cp_if.source chars
);
  import u8d_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_take;

  u8d_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  u8d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .chars      (chars)
  );

endmodule

[hdl/u8d_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_check
// port-level checks on the code point channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_check (
  input logic        clk,
  input logic        rst,
  input logic        chars_valid,
  input logic        chars_ready,
  input logic [30:0] code_point,
  input logic [2:0]  seq_length,
  input logic [1:0]  status
);
  import u8d_pkg::*;

  // stalled request holds
  `ASSERT_NEXT(a_hold, clk, rst, chars_valid && !chars_ready, chars_valid && $stable(code_point) && $stable(seq_length) && $stable(status), "stalled result changed")

  // raw bytes are single and fit in a byte
  `ASSERT_ALWAYS(a_invalid, clk, rst, !(chars_valid && status == ST_INVALID) || (seq_length == 3'd1 && code_point[30:8] == 23'd0 && code_point[7] == 1'b1), "bad invalid result")

  // truncation reports zero and a multi-byte length
  `ASSERT_ALWAYS(a_trunc, clk, rst, !(chars_valid && status == ST_TRUNC) || (code_point == 31'd0 && seq_length >= 3'd2 && seq_length <= 3'd6), "bad truncated result")

  // single-byte characters are ascii
  `ASSERT_ALWAYS(a_ascii, clk, rst, !(chars_valid && status == ST_OK && seq_length == 3'd1) || code_point < 31'd128, "bad single byte result")

endmodule

bind utf8_stream_decoder u8d_check u_check (
  .clk         (clk),
  .rst         (rst),
  .chars_valid (chars.valid),
  .chars_ready (chars.ready),
  .code_point  (chars.code_point),
  .seq_length  (chars.seq_length),
  .status      (chars.status)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives byte requests into utf8_stream_decoder and checks every code point
// request against a cycle-free decoder kept in a small scoreboard class
// ----------------------------------------------------------------------------
module testbench;
  import u8d_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_BYTES  = 40;
  localparam int RANDOM_BYTES = 880;
  localparam int QUIET_FROM   = 770;

  typedef struct {
    logic [30:0] cp;
    logic [2:0]  len;
    logic [1:0]  st;
  } char_t;

  class char_scoreboard;
    logic [2:0]  owed;
    logic [30:0] partial;
    logic [2:0]  pend_len;
    char_t       due[$];
    int unsigned errors;

    function new();
      owed     = '0;
      partial  = '0;
      pend_len = '0;
      errors   = 0;
    endfunction

    function void queue_char(logic [30:0] cp, logic [2:0] len, logic [1:0] st);
      char_t c;
      c.cp  = cp;
      c.len = len;
      c.st  = st;
      due = {due, c};
    endfunction

    function void go_idle();
      owed     = '0;
      partial  = '0;
      pend_len = '0;
    endfunction

    // advance the decoder by one accepted byte
    function void note_byte(logic [7:0] b, logic last);
      logic [2:0] len;
      logic [4:0] val;
      len = 3'd0;
      val = 5'd0;
      if (owed != 3'd0) begin
        // any byte counts as a continuation here, only six bits used
        partial = {partial[24:0], b[5:0]};
        owed = owed - 3'd1;
        if (owed == 3'd0) begin
          queue_char(partial, pend_len, ST_OK);
          go_idle();
        end else if (last) begin
          queue_char('0, pend_len, ST_TRUNC);
          go_idle();
        end
        return;
      end
      casez (b)
        8'b0???????: queue_char({23'd0, b}, 3'd1, ST_OK);
        8'b10??????: queue_char({23'd0, b}, 3'd1, ST_INVALID);
        8'b110?????: begin len = 3'd2; val = b[4:0]; end
        8'b1110????: begin len = 3'd3; val = {1'b0, b[3:0]}; end
        8'b11110???: begin len = 3'd4; val = {2'b0, b[2:0]}; end
        8'b111110??: begin len = 3'd5; val = {3'b0, b[1:0]}; end
        8'b1111110?: begin len = 3'd6; val = {4'b0, b[0]}; end
        default:     queue_char({23'd0, b}, 3'd1, ST_INVALID);
      endcase
      if (len == 3'd0) return;
      if (last) begin
        queue_char('0, len, ST_TRUNC);
        go_idle();
      end else begin
        pend_len = len;
        owed     = len - 3'd1;
        partial  = {26'd0, val};
      end
    endfunction

    function void check_char(logic [30:0] cp, logic [2:0] len, logic [1:0] st);
      char_t c;
      if (due.size() == 0) begin
        $display("%0t: unexpected code point request, actual cp %h len %0d status %0d",
                 $time, cp, len, st);
        errors++;
        return;
      end
      c = due.pop_front();
      if (cp !== c.cp) begin
        $display("%0t: code_point expected %h actual %h", $time, c.cp, cp);
        errors++;
      end
      if (len !== c.len) begin
        $display("%0t: seq_length expected %0d actual %0d", $time, c.len, len);
        errors++;
      end
      if (st !== c.st) begin
        $display("%0t: status expected %0d actual %0d", $time, c.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  u8d_byte_if text_if ();
  u8d_cp_if   chars_if ();

  utf8_stream_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .chars (chars_if)
  );

  char_scoreboard sb = new();

  bit tx_quiet    = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;
  bit rx_holding  = 1'b0;
  int unsigned bytes_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("utf8_stream_decoder test failed");
    $finish;
  end

  // result side: random ready bursts plus one long hold on request
  initial begin : receiver
    chars_if.ready <= 1'b0;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_holding  = 1'b1;
        chars_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        chars_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        chars_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready)
      sb.check_char(chars_if.code_point, chars_if.seq_length, chars_if.status);
  end

  function automatic logic end_flag();
    return ($urandom_range(0, 15) == 0);
  endfunction

  function automatic logic [7:0] lead_byte(input int unsigned len);
    case (len)
      1:       return 8'($urandom_range(0, CONT_BASE - 1));
      2:       return 8'($urandom_range(LEAD2_BASE, LEAD3_BASE - 1));
      3:       return 8'($urandom_range(LEAD3_BASE, LEAD4_BASE - 1));
      4:       return 8'($urandom_range(LEAD4_BASE, LEAD5_BASE - 1));
      5:       return 8'($urandom_range(LEAD5_BASE, LEAD6_BASE - 1));
      default: return 8'($urandom_range(LEAD6_BASE, BAD_BASE - 1));
    endcase
  endfunction

  // mostly proper 10xxxxxx bytes, sometimes anything at all
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return CONT_BASE | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!tx_quiet && $urandom_range(0, 4) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.in_byte   <= b;
    text_if.last_byte <= last;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // cut below len ends the text inside the sequence
  task automatic send_char(input int unsigned len, input int unsigned cut);
    logic [7:0] b;
    logic       last;
    for (int i = 0; i < cut; i++) begin
      b = (i == 0) ? lead_byte(len) : cont_byte();
      last = (cut < len && i == cut - 1) ? 1'b1 : end_flag();
      send_byte(b, last);
    end
  endtask

  task automatic drain();
    text_if.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  item_t directed_text [25] = '{
    '{8'h00, 1'b0}, '{8'h7F, 1'b0},
    '{8'h80, 1'b0}, '{8'hBF, 1'b0},
    '{8'hFE, 1'b0}, '{8'hFF, 1'b1},
    '{8'hC0, 1'b0}, '{8'h80, 1'b0},
    '{8'hDF, 1'b0}, '{8'hFF, 1'b0},
    '{8'hE0, 1'b0}, '{8'h41, 1'b0}, '{8'h00, 1'b0},
    '{8'hFD, 1'b0}, '{8'hBF, 1'b0}, '{8'hBF, 1'b0},
    '{8'hBF, 1'b0}, '{8'hBF, 1'b0}, '{8'hBF, 1'b1},
    '{8'hF0, 1'b0}, '{8'h80, 1'b0}, '{8'h80, 1'b1},
    '{8'hF8, 1'b1},
    '{8'hFC, 1'b1},
    '{8'h41, 1'b1}
  };

  initial begin : sender
    int unsigned pick;
    int unsigned len;
    bit          paused;
    paused = 1'b0;
    rst <= 1'b1;
    text_if.valid     <= 1'b0;
    text_if.in_byte   <= 8'h00;
    text_if.last_byte <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[i])
      send_byte(directed_text[i].in_byte, directed_text[i].last_byte);
    drain();

    // fill the block while the result side is held off
    rx_hold_req = 1'b1;
    while (!rx_holding) @(posedge clk);
    tx_quiet = 1'b1;
    repeat (HOLD_BYTES) send_byte(8'($urandom_range(0, CONT_BASE - 1)), 1'b0);
    tx_quiet = 1'b0;

    while (bytes_sent < RANDOM_BYTES) begin
      if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
        paused = 1'b1;
        drain();
      end
      if (bytes_sent > QUIET_FROM) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 6);
        send_char(len, len);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(0, CONT_BASE - 1)), end_flag());
      end else if (pick < 80) begin
        len = $urandom_range(2, 6);
        send_char(len, $urandom_range(1, len - 1));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), end_flag());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0)
      $display("utf8_stream_decoder test passed");
    else
      $display("utf8_stream_decoder test failed");
    $finish;
  end

endmodule
